### rtl/dfe_pkg.sv
// Shared types and constants of the escape-framed byte deframer.
package dfe_pkg;

	// Register widths fixed by the frame format.
	localparam int ByteW  = 8;
	localparam int TsW    = 16;
	localparam int CountW = 24;
	localparam int DeltaW = 17;
	localparam int TicksW = 32;
	localparam int PosW   = 25;
	localparam int PdelW  = 26;

	// Number of payload bytes that are captured from each frame.
	localparam int CapBytes = 6;
	localparam int CapPosW  = 3;

	// Stream packing: tdata carries the five numeric fields, tuser the kind and flag.
	localparam int OutDataW = 128;
	localparam int OutUserW = 3;
	localparam int CfgDataW = 24;

	// Register reset values.
	localparam logic [ByteW-1:0]  EscapeReset = 8'h10;
	localparam logic [ByteW-1:0]  StartReset  = 8'h02;
	localparam logic [ByteW-1:0]  EndReset    = 8'h03;
	localparam logic [CountW-1:0] WrapReset   = 24'd8000000;

	// Frame type byte codes.
	localparam logic [ByteW-1:0] TYPE_INERTIAL_A = 8'h01;
	localparam logic [ByteW-1:0] TYPE_INERTIAL_B = 8'h02;
	localparam logic [ByteW-1:0] TYPE_ENCODER    = 8'hAA;

	// Input command codes.
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// Register indexes on the configuration channel.
	typedef enum logic [1:0] {
		REG_ESCAPE = 2'd0,
		REG_START  = 2'd1,
		REG_END    = 2'd2,
		REG_WRAP   = 2'd3
	} dfe_reg_t;

	// Kind of a completed frame.
	typedef enum logic [1:0] {
		KIND_INERTIAL = 2'd0,
		KIND_ENCODER  = 2'd1,
		KIND_OTHER    = 2'd2,
		KIND_SHORT    = 2'd3
	} dfe_kind_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [ByteW-1:0]  escape_byte;
		logic [ByteW-1:0]  start_byte;
		logic [ByteW-1:0]  end_byte;
		logic [CountW-1:0] wrap_threshold;
	} dfe_cfg_t;

	// Event handed from the parser to the timing stage.
	typedef struct packed {
		logic              restart;
		dfe_kind_t         kind;
		logic [TsW-1:0]    ts;
		logic [CountW-1:0] count;
	} dfe_evt_t;

	// One result item.
	typedef struct packed {
		dfe_kind_t         frame_kind;
		logic              first_sample;
		logic [DeltaW-1:0] time_delta;
		logic [TicksW-1:0] elapsed_ticks;
		logic [CountW-1:0] encoder_count;
		logic [PosW-1:0]   position;
		logic [PdelW-1:0]  position_delta;
	} dfe_result_t;

endpackage

### rtl/dfe_parser.sv
// Byte unstuffer and frame parser, with the event stage register behind it.
module dfe_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfe_pkg::dfe_cfg_t           cfg,
	input  logic                        in_accept,
	input  logic                        command,
	input  logic [dfe_pkg::ByteW-1:0]   data_byte,
	input  logic                        evt_take,
	output logic                        evt_valid_s1,
	output dfe_pkg::dfe_evt_t           evt_s1
);
	import dfe_pkg::*;

	logic                 in_frame_q, in_frame_d;
	logic                 esc_q, esc_d;
	logic [CapPosW-1:0]   pos_q, pos_d;
	logic [ByteW-1:0]     cap_q [CapBytes];
	logic                 cap1_en, cap2_en;
	logic [ByteW-1:0]     cap1_val;
	logic [CapPosW:0]     pos_sum;
	logic [CapPosW:0]     pos_next1;
	logic                 new_evt;
	dfe_evt_t             evt_d;

	assign pos_next1 = {1'b0, pos_q} + {{CapPosW{1'b0}}, 1'b1};

	// Decode one beat: escape tracking, frame boundaries and captures.
	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		cap1_en    = 1'b0;
		cap2_en    = 1'b0;
		cap1_val   = data_byte;
		new_evt    = 1'b0;
		evt_d      = '0;
		if (command == CMD_RESTART) begin
			new_evt       = 1'b1;
			evt_d.restart = 1'b1;
		end else if (!in_frame_q) begin
			if (esc_q) begin
				esc_d = 1'b0;
				if (data_byte == cfg.start_byte) begin
					in_frame_d = 1'b1;
				end
			end else if (data_byte == cfg.escape_byte) begin
				esc_d = 1'b1;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (data_byte == cfg.end_byte) begin
				in_frame_d = 1'b0;
				new_evt    = 1'b1;
			end else begin
				// A stuffed escape, or a lone escape followed by a plain byte.
				cap1_en  = 1'b1;
				cap1_val = cfg.escape_byte;
				cap2_en  = (data_byte != cfg.escape_byte);
			end
		end else if (data_byte == cfg.escape_byte) begin
			esc_d = 1'b1;
		end else begin
			cap1_en = 1'b1;
		end

		// Frame summary for the timing stage.
		evt_d.ts    = {cap_q[2], cap_q[1]};
		evt_d.count = {cap_q[5], cap_q[4], cap_q[3]};
		if (pos_q < CapPosW'(CapBytes)) begin
			evt_d.kind = KIND_SHORT;
		end else if (cap_q[0] == TYPE_INERTIAL_A || cap_q[0] == TYPE_INERTIAL_B) begin
			evt_d.kind = KIND_INERTIAL;
		end else if (cap_q[0] == TYPE_ENCODER) begin
			evt_d.kind = KIND_ENCODER;
		end else begin
			evt_d.kind = KIND_OTHER;
		end
	end

	// The capture position saturates once all payload bytes are held.
	always_comb begin
		pos_sum = {1'b0, pos_q} + {{CapPosW{1'b0}}, cap1_en} + {{CapPosW{1'b0}}, cap2_en};
		if (!in_frame_q && esc_q && command == CMD_BYTE && data_byte == cfg.start_byte) begin
			pos_d = '0;
		end else if (pos_sum > (CapPosW+1)'(CapBytes)) begin
			pos_d = CapPosW'(CapBytes);
		end else begin
			pos_d = pos_sum[CapPosW-1:0];
		end
	end

	// Parser control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			esc_q        <= 1'b0;
			pos_q        <= '0;
			evt_valid_s1 <= 1'b0;
		end else begin
			if (in_accept) begin
				in_frame_q   <= in_frame_d;
				esc_q        <= esc_d;
				pos_q        <= pos_d;
				evt_valid_s1 <= new_evt;
			end else if (evt_take) begin
				evt_valid_s1 <= 1'b0;
			end
		end
	end

	// Captured payload bytes and the event payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			for (int i = 0; i < CapBytes; i++) begin
				if (cap1_en && pos_q == CapPosW'(i)) begin
					cap_q[i] <= cap1_val;
				end else if (cap2_en && pos_next1 == (CapPosW+1)'(i)) begin
					cap_q[i] <= data_byte;
				end
			end
			if (new_evt) begin
				evt_s1 <= evt_d;
			end
		end
	end

endmodule

### rtl/dfe_timing.sv
// Tick accounting, encoder unwrapping and the result register.
module dfe_timing (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dfe_pkg::CountW-1:0]    wrap_threshold,
	input  logic                          evt_valid_s1,
	input  dfe_pkg::dfe_evt_t             evt_s1,
	input  logic                          out_ready,
	output logic                          evt_take,
	output logic                          out_valid,
	output dfe_pkg::dfe_result_t          result
);
	import dfe_pkg::*;

	logic              awaiting_q;
	logic [TicksW-1:0] elapsed_q;
	logic [TsW-1:0]    last_ts_q;
	logic [CountW-1:0] last_count_q;
	logic              wrap_q;
	logic [PosW-1:0]   last_pos_q;
	logic              out_valid_q;
	dfe_result_t       res_q;

	logic              is_frame, is_timed, is_enc;
	logic [TsW-1:0]    d16;
	logic [DeltaW-1:0] delta;
	logic [TicksW-1:0] elapsed_new;
	logic signed [PosW-1:0] diff, thr_s;
	logic              wrap_next;
	logic [PosW-1:0]   pos;
	logic [PdelW-1:0]  pdelta;
	dfe_result_t       res_d;

	// The event stage drains whenever the result register can take a beat.
	assign evt_take  = evt_valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign result    = res_q;

	assign is_frame = evt_take && !evt_s1.restart;
	assign is_timed = evt_s1.kind == KIND_INERTIAL || evt_s1.kind == KIND_ENCODER;
	assign is_enc   = evt_s1.kind == KIND_ENCODER;

	// Tick delta: an equal timestamp counts as a full 16-bit wrap.
	always_comb begin
		d16 = evt_s1.ts - last_ts_q;
		if (!is_timed || awaiting_q) begin
			delta = '0;
		end else if (d16 == '0) begin
			delta = DeltaW'(1 << TsW);
		end else begin
			delta = {1'b0, d16};
		end
		elapsed_new = elapsed_q + TicksW'(delta);
	end

	// Encoder unwrapping from the jump against the previous count.
	always_comb begin
		diff  = $signed({1'b0, evt_s1.count}) - $signed({1'b0, last_count_q});
		thr_s = $signed({1'b0, wrap_threshold});
		if (diff > thr_s) begin
			wrap_next = 1'b1;
		end else if (diff < -thr_s) begin
			wrap_next = 1'b0;
		end else begin
			wrap_next = wrap_q;
		end
		pos    = {1'b0, evt_s1.count} - {wrap_next, {CountW{1'b0}}};
		pdelta = {pos[PosW-1], pos} - {last_pos_q[PosW-1], last_pos_q};
	end

	// Assemble the result beat.
	always_comb begin
		res_d                = '0;
		res_d.frame_kind     = evt_s1.kind;
		res_d.first_sample   = is_timed && awaiting_q;
		res_d.time_delta     = delta;
		res_d.elapsed_ticks  = is_timed ? elapsed_new : elapsed_q;
		if (is_enc) begin
			res_d.encoder_count  = evt_s1.count;
			res_d.position       = pos;
			res_d.position_delta = awaiting_q ? '0 : pdelta;
		end
	end

	// Timing and encoder state, plus the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b1;
			elapsed_q    <= '0;
			last_ts_q    <= '0;
			last_count_q <= '0;
			wrap_q       <= 1'b0;
			last_pos_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (evt_take && evt_s1.restart) begin
				awaiting_q <= 1'b1;
				elapsed_q  <= '0;
			end else if (is_frame && is_timed) begin
				awaiting_q <= 1'b0;
				elapsed_q  <= elapsed_new;
				last_ts_q  <= evt_s1.ts;
			end
			if (is_frame && is_enc) begin
				last_count_q <= evt_s1.count;
				wrap_q       <= wrap_next;
				last_pos_q   <= pos;
			end
			if (is_frame) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (is_frame) begin
			res_q <= res_d;
		end
	end

endmodule

### rtl/dle_frame_encoder_decoder.sv
// Top level of the escape-framed byte deframer with tick and encoder tracking.
//
// Input stream (s_*): one beat per serial byte; s_tuser is the command
// (0 byte, 1 restart of the tick timing) and s_tdata the byte. A byte is
// unstuffed and parsed in the cycle it is accepted, one beat per cycle
// while s_tready is high. Output stream (m_*): one beat for each frame
// closed by escape, end. A frame-closing beat reaches m_* through the
// event stage register and the result register. Bytes that close no
// frame give nothing. Configuration (cfg_*): register index and value,
// always ready; write only while the block is idle.
// Throughput is one beat per cycle, set by the single event stage between
// parser and result register; it holds while m_tready is high.
// Reset clears the parser to hunting, marks the next timed frame as the
// first sample, zeroes the tick and encoder state and reloads register
// defaults. When the receiver stalls, the result register holds its beat.
// A frame end or a restart that follows waits in the event stage, and
// s_tready stays low from then until the receiver takes the held result.
module dle_frame_encoder_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input stream.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic [0:0]                    s_tuser,   // [0] command
	// Result stream.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [16:0] time_delta, [48:17] elapsed_ticks, [72:49] encoder_count,
	// [97:73] position, [123:98] position_delta, [127:124] zero
	output logic [dfe_pkg::OutDataW-1:0]  m_tdata,
	output logic [dfe_pkg::OutUserW-1:0]  m_tuser,   // [1:0] frame_kind, [2] first_sample
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [dfe_pkg::CfgDataW-1:0]  cfg_data
);
	import dfe_pkg::*;

	dfe_cfg_t    cfg_q;
	logic        in_accept;
	logic        evt_take;
	logic        evt_valid_s1;
	dfe_evt_t    evt_s1;
	dfe_result_t result;

	assign cfg_ready = 1'b1;
	assign s_tready  = !evt_valid_s1 || evt_take;
	assign in_accept = s_tvalid && s_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_byte    <= EscapeReset;
			cfg_q.start_byte     <= StartReset;
			cfg_q.end_byte       <= EndReset;
			cfg_q.wrap_threshold <= WrapReset;
		end else if (cfg_valid && cfg_ready) begin
			case (dfe_reg_t'(cfg_index))
				REG_ESCAPE: cfg_q.escape_byte    <= cfg_data[ByteW-1:0];
				REG_START:  cfg_q.start_byte     <= cfg_data[ByteW-1:0];
				REG_END:    cfg_q.end_byte       <= cfg_data[ByteW-1:0];
				REG_WRAP:   cfg_q.wrap_threshold <= cfg_data[CountW-1:0];
				default: begin
				end
			endcase
		end
	end

	dfe_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_accept    (in_accept),
		.command      (s_tuser[0]),
		.data_byte    (s_tdata),
		.evt_take     (evt_take),
		.evt_valid_s1 (evt_valid_s1),
		.evt_s1       (evt_s1)
	);

	dfe_timing u_timing (
		.clk            (clk),
		.arst_n         (arst_n),
		.wrap_threshold (cfg_q.wrap_threshold),
		.evt_valid_s1   (evt_valid_s1),
		.evt_s1         (evt_s1),
		.out_ready      (m_tready),
		.evt_take       (evt_take),
		.out_valid      (m_tvalid),
		.result         (result)
	);

	// Pack the result beat onto the stream.
	assign m_tdata = {4'b0, result.position_delta, result.position, result.encoder_count,
		result.elapsed_ticks, result.time_delta};
	assign m_tuser = {result.first_sample, result.frame_kind};

endmodule

### tb/testbench.sv
// Self-checking testbench for the escape-framed byte deframer with tick and encoder tracking.
`timescale 1ns / 1ps

module testbench;
	import dfe_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [7:0] data_byte
	logic [0:0]           s_tuser;   // [0] command
	logic                 m_tvalid;
	logic                 m_tready;
	// [16:0] time_delta, [48:17] elapsed_ticks, [72:49] encoder_count,
	// [97:73] position, [123:98] position_delta, [127:124] zero
	logic [OutDataW-1:0]  m_tdata;
	logic [OutUserW-1:0]  m_tuser;   // [1:0] frame_kind, [2] first_sample
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [1:0]           cfg_index;
	logic [CfgDataW-1:0]  cfg_data;

	dle_frame_encoder_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies held by the predictor.
	logic [7:0]  reg_escape;
	logic [7:0]  reg_start;
	logic [7:0]  reg_end;
	logic [23:0] reg_wrap;

	// Parser, timing and encoder state of the predictor.
	bit          in_frame;
	bit          escape_seen;
	int          payload_len;
	logic [47:0] payload;
	int          prev_ts;
	bit          wait_first;
	logic [31:0] ticks;
	logic [23:0] prev_count;
	bit          wrap_on;
	int          prev_pos;

	dfe_result_t frames_due[$];
	int          failures;
	int          beats_sent;
	bit          tx_gaps_on;
	bit          rx_stalls_on;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes long before this.
	initial begin
		#2000000;
		$display("[dle_frame_encoder_decoder] ERROR");
		$finish;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Stores one unstuffed payload byte while fewer than six are held.
	function automatic void stash_byte(input logic [7:0] b);
		if (payload_len < CapBytes) begin
			payload[8*payload_len +: 8] = b;
			payload_len++;
		end
	endfunction

	// Advances the deframer state by one input beat; returns 1 when a frame closes.
	function automatic bit deframe_beat(input logic cmd, input logic [7:0] b,
			output dfe_result_t res);
		dfe_kind_t   kind;
		logic [7:0]  type_b;
		logic [23:0] cnt;
		int          ts;
		int          delta;
		int          diff;
		int          pos;
		res = '0;
		if (cmd == CMD_RESTART) begin
			wait_first = 1'b1;
			ticks = '0;
			return 1'b0;
		end
		// Hunting: only escape, start opens a frame.
		if (!in_frame) begin
			if (escape_seen) begin
				escape_seen = 1'b0;
				if (b == reg_start) begin
					in_frame = 1'b1;
					payload_len = 0;
					payload = '0;
				end
			end else if (b == reg_escape) begin
				escape_seen = 1'b1;
			end
			return 1'b0;
		end
		// Inside a frame: unstuff, or close on escape, end.
		if (escape_seen) begin
			escape_seen = 1'b0;
			if (b != reg_end) begin
				stash_byte(reg_escape);
				if (b != reg_escape)
					stash_byte(b);
				return 1'b0;
			end
		end else begin
			if (b == reg_escape)
				escape_seen = 1'b1;
			else
				stash_byte(b);
			return 1'b0;
		end
		// Frame closed: classify it and update timing and position.
		type_b = payload[7:0];
		if (payload_len < CapBytes)
			kind = KIND_SHORT;
		else if (type_b == TYPE_INERTIAL_A || type_b == TYPE_INERTIAL_B)
			kind = KIND_INERTIAL;
		else if (type_b == TYPE_ENCODER)
			kind = KIND_ENCODER;
		else
			kind = KIND_OTHER;
		res.frame_kind = kind;
		if (kind == KIND_INERTIAL || kind == KIND_ENCODER) begin
			ts = int'(payload[23:8]);
			if (wait_first) begin
				res.first_sample = 1'b1;
				wait_first = 1'b0;
			end else begin
				delta = (ts > prev_ts) ? ts - prev_ts : 65536 - prev_ts + ts;
				ticks = ticks + 32'(delta);
				res.time_delta = 17'(delta);
			end
			prev_ts = ts;
		end
		if (kind == KIND_ENCODER) begin
			cnt = payload[47:24];
			diff = int'(cnt) - int'(prev_count);
			if (diff > int'(reg_wrap))
				wrap_on = 1'b1;
			else if (diff < -int'(reg_wrap))
				wrap_on = 1'b0;
			pos = int'(cnt) - (wrap_on ? 16777216 : 0);
			res.encoder_count = cnt;
			res.position = 25'(pos);
			if (!res.first_sample)
				res.position_delta = 26'(pos - prev_pos);
			prev_count = cnt;
			prev_pos = pos;
		end
		res.elapsed_ticks = ticks;
		in_frame = 1'b0;
		return 1'b1;
	endfunction

	// Sends one input beat after a random gap and predicts its result.
	task automatic send_beat(input logic cmd, input logic [7:0] b);
		int          gap;
		dfe_result_t res;
		gap = tx_gaps_on ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		beats_sent++;
		if (deframe_beat(cmd, b, res))
			frames_due.insert(frames_due.size(), res);
	endtask

	// Sends escape, start, the stuffed body and, if asked, escape, end.
	// A lone escape goes out just before body byte lone_at.
	task automatic send_frame(input byte_q_t body, input int lone_at, input bit close);
		send_beat(CMD_BYTE, reg_escape);
		send_beat(CMD_BYTE, reg_start);
		foreach (body[i]) begin
			if (i == lone_at || body[i] == reg_escape)
				send_beat(CMD_BYTE, reg_escape);
			send_beat(CMD_BYTE, body[i]);
		end
		if (close) begin
			send_beat(CMD_BYTE, reg_escape);
			send_beat(CMD_BYTE, reg_end);
		end
	endtask

	function automatic byte_q_t make_body(input logic [7:0] type_b, input logic [15:0] ts,
			input logic [23:0] cnt);
		make_body = {type_b, ts[7:0], ts[15:8], cnt[7:0], cnt[15:8], cnt[23:16]};
	endfunction

	// Holds the sender idle until every result has come and the pipeline is empty.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes one register; byte registers get random bits above the byte.
	task automatic write_reg(input dfe_reg_t idx, input logic [23:0] val);
		logic [23:0] word;
		word = val;
		if (idx != REG_WRAP)
			word[23:8] = 16'($urandom);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ESCAPE: reg_escape = word[7:0];
			REG_START:  reg_start = word[7:0];
			REG_END:    reg_end = word[7:0];
			default:    reg_wrap = word;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [7:0] esc, input logic [7:0] stx,
			input logic [7:0] etx, input logic [23:0] wrap);
		drain_results();
		write_reg(REG_ESCAPE, {16'd0, esc});
		write_reg(REG_START, {16'd0, stx});
		write_reg(REG_END, {16'd0, etx});
		write_reg(REG_WRAP, wrap);
	endtask

	// Random frame body: mostly well-formed, some short, long or of other type.
	function automatic byte_q_t random_body();
		byte_q_t     body;
		logic [7:0]  type_b;
		logic [15:0] ts;
		logic [23:0] cnt;
		int          sel;
		int          len;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			type_b = TYPE_ENCODER;
		else if (sel < 6)
			type_b = TYPE_INERTIAL_A;
		else if (sel < 8)
			type_b = TYPE_INERTIAL_B;
		else
			type_b = 8'($urandom);
		ts = ($urandom_range(0, 7) == 0) ? 16'(prev_ts) : 16'($urandom);
		case ($urandom_range(0, 5))
			0: cnt = prev_count ^ 24'h800000;
			1: cnt = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
			2: cnt = 24'(int'(prev_count) + int'($urandom_range(0, 64)) - 32);
			default: cnt = 24'($urandom);
		endcase
		body = make_body(type_b, ts, cnt);
		len = $urandom_range(0, 11);
		if (len < 6 && $urandom_range(0, 3) == 0) begin
			while (body.size() > len)
				void'(body.pop_back());
		end else if (len > 9) begin
			repeat (len - 6) body.insert(body.size(), 8'($urandom));
		end
		// Now and then put a framing byte into the payload.
		if (body.size() > 1 && $urandom_range(0, 4) == 0)
			body[$urandom_range(1, body.size() - 1)] =
				$urandom_range(0, 1) ? reg_escape : reg_end;
		return body;
	endfunction

	// Random traffic: frames with noise, restarts, lone escapes and open frames.
	task automatic random_traffic(input int beats);
		int      stop_at;
		int      lone_at;
		byte_q_t body;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			tx_gaps_on = ($urandom_range(0, 4) != 0);
			rx_stalls_on = ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 11))
				0: repeat ($urandom_range(1, 4))
					send_beat(CMD_BYTE, $urandom_range(0, 2) == 0 ? reg_escape : 8'($urandom));
				1: send_beat(CMD_RESTART, 8'($urandom));
				default: ;
			endcase
			body = random_body();
			lone_at = ($urandom_range(0, 7) == 0 && body.size() > 0) ?
				$urandom_range(0, body.size() - 1) : -1;
			send_frame(body, lone_at, $urandom_range(0, 15) != 0);
		end
	endtask

	// Timing from reset: first sample, equal timestamp, wrap of the 16-bit timestamp counter,
	// encoder wrap in both directions and a restart.
	task automatic test_timing();
		send_frame(make_body(TYPE_INERTIAL_A, 16'h0000, 24'h0), -1, 1'b1);
		send_frame(make_body(TYPE_INERTIAL_B, 16'h0000, 24'h0), -1, 1'b1);
		send_frame(make_body(TYPE_ENCODER, 16'hFFFF, 24'hFFFFFF), -1, 1'b1);
		send_frame(make_body(TYPE_ENCODER, 16'h0001, 24'h000000), -1, 1'b1);
		send_beat(CMD_RESTART, 8'hFF);
		send_frame(make_body(TYPE_ENCODER, 16'h8000, 24'h7FFFFF), -1, 1'b1);
	endtask

	// Framing cases: pairs and stray bytes while hunting, lone escape, unescaped
	// end byte, short, other type, long and stuffed frames.
	task automatic test_framing();
		byte_q_t body;
		send_beat(CMD_BYTE, reg_escape);
		send_beat(CMD_BYTE, reg_escape);
		send_beat(CMD_BYTE, reg_start);
		send_beat(CMD_BYTE, reg_escape);
		send_beat(CMD_BYTE, 8'h55);
		send_frame(make_body(TYPE_INERTIAL_A, 16'h1234, 24'h0), 3, 1'b1);
		send_frame(make_body(TYPE_INERTIAL_B, {8'h00, reg_end}, 24'h0), -1, 1'b1);
		body = {TYPE_ENCODER, 8'h01, 8'h02};
		send_frame(body, -1, 1'b1);
		send_frame(make_body(8'h55, 16'hABCD, 24'h123456), -1, 1'b1);
		body = make_body(TYPE_ENCODER, 16'hFFFE, 24'h000100);
		repeat (4) body.insert(body.size(), 8'hC3);
		send_frame(body, -1, 1'b1);
		send_frame(make_body(TYPE_ENCODER, {reg_escape, reg_escape}, {reg_escape, 16'h0010}),
			-1, 1'b1);
	endtask

	// Extreme and coinciding register settings.
	task automatic test_register_extremes();
		write_all_regs(8'h00, 8'hFF, 8'h00, 24'd0);
		send_frame(make_body(TYPE_ENCODER, 16'h0100, 24'h000001), -1, 1'b1);
		send_frame(make_body(TYPE_ENCODER, 16'h0200, 24'h000000), -1, 1'b1);
		send_frame(make_body(TYPE_INERTIAL_A, 16'h0300, 24'h0), -1, 1'b1);
		write_all_regs(8'hFF, 8'hFF, 8'h7E, 24'hFFFFFF);
		send_frame(make_body(TYPE_ENCODER, 16'hFF00, 24'hFFFFFF), -1, 1'b1);
		send_frame(make_body(TYPE_ENCODER, 16'h00FF, 24'h000000), 2, 1'b1);
		send_beat(CMD_RESTART, 8'h00);
		send_frame(make_body(TYPE_INERTIAL_B, 16'h7E7E, 24'h0), -1, 1'b1);
	endtask

	// Random traffic under several register settings.
	task automatic test_random();
		logic [7:0] esc;
		write_all_regs(EscapeReset, StartReset, EndReset, WrapReset);
		random_traffic(80);
		write_all_regs(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
		random_traffic(70);
		esc = 8'($urandom);
		write_all_regs(esc, 8'($urandom), $urandom_range(0, 1) ? esc : 8'($urandom),
			24'($urandom_range(0, 1000)));
		random_traffic(70);
		write_all_regs(EscapeReset, StartReset, EndReset, 24'hFFFFFF);
		random_traffic(80);
	endtask

	// Receiver: random stalls, with stretches of none.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0)
				stall_left--;
			else if (rx_stalls_on && $urandom_range(0, 2) == 0)
				stall_left = pick_gap();
			m_tready <= (stall_left == 0);
		end
	end

	// Checks each result beat against the oldest expected frame result.
	initial begin
		dfe_result_t got;
		dfe_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.frame_kind = dfe_kind_t'(m_tuser[1:0]);
				got.first_sample = m_tuser[2];
				got.time_delta = m_tdata[16:0];
				got.elapsed_ticks = m_tdata[48:17];
				got.encoder_count = m_tdata[72:49];
				got.position = m_tdata[97:73];
				got.position_delta = m_tdata[123:98];
				if (frames_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result beat with none expected: %p", $realtime, got);
				end else begin
					want = frames_due[0];
					frames_due.delete(0);
					if (got.frame_kind !== want.frame_kind ||
							got.first_sample !== want.first_sample ||
							got.time_delta !== want.time_delta ||
							got.elapsed_ticks !== want.elapsed_ticks ||
							got.encoder_count !== want.encoder_count ||
							got.position !== want.position ||
							got.position_delta !== want.position_delta) begin
						failures++;
						if (failures <= 10)
							$display("%0t: mismatch\n  expected %p\n  actual   %p",
								$realtime, want, got);
					end
				end
			end
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_BYTE;
		cfg_valid = 1'b0;
		cfg_index = REG_ESCAPE;
		cfg_data = '0;
		arst_n = 1'b0;
		failures = 0;
		beats_sent = 0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		reg_escape = EscapeReset;
		reg_start = StartReset;
		reg_end = EndReset;
		reg_wrap = WrapReset;
		in_frame = 1'b0;
		escape_seen = 1'b0;
		payload_len = 0;
		payload = '0;
		prev_ts = 0;
		wait_first = 1'b1;
		ticks = '0;
		prev_count = '0;
		wrap_on = 1'b0;
		prev_pos = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_timing();
		test_framing();
		test_register_extremes();
		test_random();
		drain_results();
		repeat (10) @(posedge clk);

		if (failures == 0 && frames_due.size() == 0)
			$display("[dle_frame_encoder_decoder] OK");
		else
			$display("[dle_frame_encoder_decoder] ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/dfe_pkg.sv
rtl/dfe_parser.sv
rtl/dfe_timing.sv
rtl/dle_frame_encoder_decoder.sv
tb/testbench.sv
